[design/assert_macros.svh]
// Assertion macros used by the checker file rbi_checker.sv.
// No dependencies; include guard below.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RBI_ASSERT_NOW(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RBI_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

[design/rbi_pkg.sv]
// Shared types and constants for the ray/box intersection pipeline.
// No dependencies.
package rbi_pkg;

   localparam int NUM_AXES = 3;
   localparam int FIELD_W  = 32;

   typedef logic [1:0] cls_type;
   localparam cls_type CLS_BELOW  = 2'd0;
   localparam cls_type CLS_ABOVE  = 2'd1;
   localparam cls_type CLS_WITHIN = 2'd2;

   typedef logic [1:0] axis_idx_type;

   // Per-axis control flags carried down the pipe.
   typedef struct packed {
      cls_type cls;
      logic    skip;   // distance forced to minus one
      logic    neg;    // distance is negative
      logic    dneg;   // direction is negative
   } axis_ctl_type;

endpackage

[design/rbi_classify.sv]
// Per-axis slab classification, plane distance numerator and direction magnitude.
// Uses rbi_pkg.
module rbi_classify import rbi_pkg::*; #(
   parameter int CW = 32
) (
   input  logic [CW-1:0] bmin,
   input  logic [CW-1:0] bmax,
   input  logic [CW-1:0] org,
   input  logic [CW-1:0] dir,
   output axis_ctl_type  ctl,
   output logic [CW-1:0] mag,
   output logic [CW-1:0] dmag
);

   always_comb begin
      ctl.dneg = dir[CW-1];
      if ($signed(org) < $signed(bmin)) begin
         ctl.cls = CLS_BELOW;
      end else if ($signed(bmax) < $signed(org)) begin
         ctl.cls = CLS_ABOVE;
      end else begin
         ctl.cls = CLS_WITHIN;
      end
      ctl.skip = (ctl.cls == CLS_WITHIN) || (dir == '0);
      ctl.neg  = (ctl.cls == CLS_ABOVE) != ctl.dneg;
      mag      = (ctl.cls == CLS_BELOW) ? (bmin - org) : (org - bmax);
      dmag     = ctl.dneg ? (~dir + 1'b1) : dir;
   end

endmodule

[design/rbi_div.sv]
// Pipelined restoring divider: (mag << FB) / den, one quotient bit per stage.
// Standalone. Flags quotients of 2^CW or more.
module rbi_div #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic          clock,
   input  logic          en,
   input  logic [CW-1:0] mag,
   input  logic [CW-1:0] den,
   output logic [CW-1:0] quo,
   output logic          ovf
);

   localparam int NW   = CW + FB;
   localparam int CMPW = ((FB > CW) ? FB : CW) + 1;

   logic [NW-1:0]   num;
   logic [CMPW-1:0] hi_cmp;
   logic [CMPW-1:0] den_cmp;

   logic [CW-1:0] rem_ff [0:CW];
   logic [CW-1:0] q_ff   [0:CW];
   logic [CW-1:0] lo_ff  [0:CW];
   logic [CW-1:0] den_ff [0:CW];
   logic          ovf_ff [0:CW];

   assign num     = {mag, {FB{1'b0}}};
   assign hi_cmp  = CMPW'(num[NW-1:CW]);
   assign den_cmp = CMPW'(den);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= CW'(num[NW-1:CW]);
         lo_ff[0]  <= num[CW-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= hi_cmp >= den_cmp;
      end
   end

   for (genvar k = 1; k <= CW; k++) begin : g_stage
      logic [CW:0] trial;
      logic        ge;
      assign trial = {rem_ff[k-1], lo_ff[k-1][CW-1]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? CW'(trial - {1'b0, den_ff[k-1]}) : trial[CW-1:0];
            q_ff[k]   <= {q_ff[k-1][CW-2:0], ge};
            lo_ff[k]  <= lo_ff[k-1] << 1;
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = q_ff[CW];
   assign ovf = ovf_ff[CW];

endmodule

[design/rbi_scale.sv]
// Registered per-axis offset t * dir, shifted by FB and saturated.
// Uses rbi_pkg.
module rbi_scale import rbi_pkg::*; #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  logic          clock,
   input  logic          en,
   input  logic [CW-1:0] tw,
   input  logic [CW-1:0] dmag,
   input  axis_ctl_type  ctl,
   output logic [CW-1:0] offs
);

   localparam int PW = 2 * CW;
   localparam int RW = PW - FB;

   logic [PW-1:0] prod;
   logic [RW-1:0] shr;
   logic [CW-1:0] lim;
   logic [CW-1:0] pm;
   logic [CW-1:0] offs_in;
   logic [CW-1:0] offs_ff;

   always_comb begin
      prod    = PW'(tw) * PW'(dmag);
      shr     = prod[PW-1:FB];
      lim     = ctl.dneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      pm      = (shr > RW'(lim)) ? lim : shr[CW-1:0];
      offs_in = ctl.dneg ? (~pm + 1'b1) : pm;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         offs_ff <= offs_in;
      end
   end

   assign offs = offs_ff;

endmodule

[design/ray_box_intersection_top.sv]
// Ray versus axis-aligned box test, signed fixed point, fully pipelined.
// Throughput: one item per cycle while the output is not stalled; the per-bit divider stages set the depth.
// Stall: a held output item with rsp_tready low freezes every stage; req_tready follows it.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
// Uses rbi_pkg, rbi_classify, rbi_div, rbi_scale.
module ray_box_intersection_top import rbi_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
   // ray_origin_x, ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_x, hit_y, hit_z
   output logic [95:0]  rsp_tdata,
   // hit
   output logic [0:0]   rsp_tuser
);

   localparam int CW  = COORD_WIDTH;
   localparam int DLY = CW + 1;   // divider depth

   localparam logic [63:0]   ONE_Q     = 64'd1 << FRAC_BITS;
   localparam logic [CW-1:0] SIGN_MIN  = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] SIGN_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MINUS_ONE =
      (FRAC_BITS < CW - 1) ? CW'(~ONE_Q + 64'd1) : SIGN_MIN;

   typedef struct packed {
      logic                                in_box;
      axis_ctl_type [NUM_AXES-1:0]         ctl;
      logic         [NUM_AXES-1:0][CW-1:0] bmin;
      logic         [NUM_AXES-1:0][CW-1:0] bmax;
      logic         [NUM_AXES-1:0][CW-1:0] org;
      logic         [NUM_AXES-1:0][CW-1:0] dmag;
   } ctx_type;

   // low CW bits of the field, sign extended when the word is wider
   function automatic logic [CW-1:0] to_cw(input logic [FIELD_W-1:0] f);
      logic [63:0] e;
      e = {{32{f[FIELD_W-1]}}, f};
      return e[CW-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] v);
      logic [63:0] e;
      e = 64'(v);
      return e[FIELD_W-1:0];
   endfunction

   // global advance: whole pipe moves unless the output holds an untaken item
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---- stage 1: classify ----
   ctx_type                    ctx_c;
   logic [NUM_AXES-1:0][CW-1:0] mag_c;
   logic [NUM_AXES-1:0][CW-1:0] dir_c;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_cls
      assign ctx_c.bmin[i] = to_cw(req_tdata[FIELD_W*i +: FIELD_W]);
      assign ctx_c.bmax[i] = to_cw(req_tdata[FIELD_W*(3+i) +: FIELD_W]);
      assign ctx_c.org[i]  = to_cw(req_tdata[FIELD_W*(6+i) +: FIELD_W]);
      assign dir_c[i]      = to_cw(req_tdata[FIELD_W*(9+i) +: FIELD_W]);
      rbi_classify #(.CW(CW)) u_cls (
         .bmin (ctx_c.bmin[i]),
         .bmax (ctx_c.bmax[i]),
         .org  (ctx_c.org[i]),
         .dir  (dir_c[i]),
         .ctl  (ctx_c.ctl[i]),
         .mag  (mag_c[i]),
         .dmag (ctx_c.dmag[i])
      );
   end
   assign ctx_c.in_box = (ctx_c.ctl[0].cls == CLS_WITHIN) &&
                         (ctx_c.ctl[1].cls == CLS_WITHIN) &&
                         (ctx_c.ctl[2].cls == CLS_WITHIN);

   logic                        vld_s1_ff;
   ctx_type                     ctx_s1_ff;
   logic [NUM_AXES-1:0][CW-1:0] mag_s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s1_ff <= 1'b0;
      end else if (en) begin
         vld_s1_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ctx_s1_ff <= ctx_c;
         mag_s1_ff <= mag_c;
      end
   end

   // ---- divider stages ----
   logic [NUM_AXES-1:0][CW-1:0] quo;
   logic [NUM_AXES-1:0]         qovf;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_div
      rbi_div #(.CW(CW), .FB(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (en),
         .mag   (mag_s1_ff[i]),
         .den   (ctx_s1_ff.dmag[i]),
         .quo   (quo[i]),
         .ovf   (qovf[i])
      );
   end

   ctx_type          ctx_dly_ff [0:DLY-1];
   logic [DLY-1:0]   vld_dly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_dly_ff <= '0;
      end else if (en) begin
         vld_dly_ff <= {vld_dly_ff[DLY-2:0], vld_s1_ff};
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ctx_dly_ff[0] <= ctx_s1_ff;
         for (int k = 1; k < DLY; k++) begin
            ctx_dly_ff[k] <= ctx_dly_ff[k-1];
         end
      end
   end

   // ---- stage 2: saturate and sign the distances ----
   ctx_type                     ctx_d;
   logic [NUM_AXES-1:0][CW-1:0] t_in;
   logic [NUM_AXES-1:0][CW-1:0] lim_t;
   logic [NUM_AXES-1:0][CW-1:0] qs;

   assign ctx_d = ctx_dly_ff[DLY-1];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         lim_t[i] = ctx_d.ctl[i].neg ? SIGN_MIN : SIGN_MAX;
         qs[i]    = (qovf[i] || (quo[i] > lim_t[i])) ? lim_t[i] : quo[i];
         if (ctx_d.ctl[i].skip) begin
            t_in[i] = MINUS_ONE;
         end else begin
            t_in[i] = ctx_d.ctl[i].neg ? (~qs[i] + 1'b1) : qs[i];
         end
      end
   end

   logic                        vld_s2_ff;
   ctx_type                     ctx_s2_ff;
   logic [NUM_AXES-1:0][CW-1:0] t_s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s2_ff <= 1'b0;
      end else if (en) begin
         vld_s2_ff <= vld_dly_ff[DLY-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ctx_s2_ff <= ctx_d;
         t_s2_ff   <= t_in;
      end
   end

   // ---- stage 3: largest distance, ties to the lower axis ----
   axis_idx_type w_in;
   logic [CW-1:0] tw_in;

   always_comb begin
      w_in  = 2'd0;
      tw_in = t_s2_ff[0];
      if ($signed(tw_in) < $signed(t_s2_ff[1])) begin
         w_in  = 2'd1;
         tw_in = t_s2_ff[1];
      end
      if ($signed(tw_in) < $signed(t_s2_ff[2])) begin
         w_in  = 2'd2;
         tw_in = t_s2_ff[2];
      end
   end

   logic          vld_s3_ff;
   ctx_type       ctx_s3_ff;
   axis_idx_type  w_s3_ff;
   logic [CW-1:0] tw_s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s3_ff <= 1'b0;
      end else if (en) begin
         vld_s3_ff <= vld_s2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ctx_s3_ff <= ctx_s2_ff;
         w_s3_ff   <= w_in;
         tw_s3_ff  <= tw_in;
      end
   end

   // ---- stage 4: offsets along the other axes ----
   logic [NUM_AXES-1:0][CW-1:0] offs;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_scale
      rbi_scale #(.CW(CW), .FB(FRAC_BITS)) u_scale (
         .clock (clock),
         .en    (en),
         .tw    (tw_s3_ff),
         .dmag  (ctx_s3_ff.dmag[i]),
         .ctl   (ctx_s3_ff.ctl[i]),
         .offs  (offs[i])
      );
   end

   logic         vld_s4_ff;
   ctx_type      ctx_s4_ff;
   axis_idx_type w_s4_ff;
   logic         twneg_s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s4_ff <= 1'b0;
      end else if (en) begin
         vld_s4_ff <= vld_s3_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ctx_s4_ff   <= ctx_s3_ff;
         w_s4_ff     <= w_s3_ff;
         twneg_s4_ff <= tw_s3_ff[CW-1];
      end
   end

   // ---- stage 5: hit point, bounds check, output register ----
   logic [NUM_AXES-1:0][CW-1:0] sum;
   logic [NUM_AXES-1:0][CW-1:0] crd;
   logic [NUM_AXES-1:0]         ok;
   logic                        hit_in;
   logic [95:0]                 data_in;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sum[i] = ctx_s4_ff.org[i] + offs[i];
         if (w_s4_ff == axis_idx_type'(i)) begin
            crd[i] = (ctx_s4_ff.ctl[i].cls == CLS_BELOW) ? ctx_s4_ff.bmin[i]
                                                         : ctx_s4_ff.bmax[i];
            ok[i]  = 1'b1;
         end else begin
            crd[i] = sum[i];
            // signed overflow of the add can never land inside the box
            ok[i]  = !(~(ctx_s4_ff.org[i][CW-1] ^ offs[i][CW-1]) &
                       (ctx_s4_ff.org[i][CW-1] ^ sum[i][CW-1])) &&
                     !($signed(sum[i]) < $signed(ctx_s4_ff.bmin[i])) &&
                     !($signed(ctx_s4_ff.bmax[i]) < $signed(sum[i]));
         end
      end
      if (ctx_s4_ff.in_box) begin
         hit_in  = 1'b1;
         data_in = {to_field(ctx_s4_ff.org[2]), to_field(ctx_s4_ff.org[1]),
                    to_field(ctx_s4_ff.org[0])};
      end else if (!twneg_s4_ff && (&ok)) begin
         hit_in  = 1'b1;
         data_in = {to_field(crd[2]), to_field(crd[1]), to_field(crd[0])};
      end else begin
         hit_in  = 1'b0;
         data_in = '0;
      end
   end

   logic        rsp_vld_ff;
   logic        rsp_hit_ff;
   logic [95:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= vld_s4_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff  <= hit_in;
         rsp_data_ff <= data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[design/rbi_checker.sv]
// Port-level checks for ray_box_intersection_top, bound to every instance.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module rbi_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [383:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   logic unused_in;
   assign unused_in = req_tvalid ^ (^req_tdata);

   // a held result keeps its payload
   `RBI_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp item changed while stalled")

   // a miss carries zero coordinates
   `RBI_ASSERT_NOW(a_miss_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0, "miss item with nonzero point")

   // input side never waits on an empty output
   `RBI_ASSERT_NOW(a_ready_free, !rsp_tvalid, req_tready, "req stalled with no pending rsp")

   // nothing comes out right after reset
   `RBI_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_tvalid, "rsp valid right after reset")

endmodule

bind ray_box_intersection_top rbi_checker u_rbi_checker (.*);

[tb/sv/ray_box_intersection_top_tb.sv]
// Testbench for the ray/box intersection pipeline: directed and random rays,
// a behavioral predictor and an in-order result checker. Depends on rbi_pkg
// and ray_box_intersection_top.
module ray_box_intersection_top_tb import rbi_pkg::*; ;

   localparam int CW   = 32;
   localparam int FB   = 16;
   localparam int LAT  = CW + 6;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic signed [31:0] q_type;

   typedef struct packed {
      logic  hit;
      q_type x;
      q_type y;
      q_type z;
   } hit_rec_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [383:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   hit_rec_type expected_hits[$];
   int          fail_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   longint      cycle_count = 0;

   ray_box_intersection_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Saturate a wide signed value to the Q16.16 word.
   function automatic q_type sat_q(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Expected hit record for one ray/box pair.
   function automatic hit_rec_type trace_ray(input q_type bmin[3], input q_type bmax[3],
                                             input q_type org[3], input q_type dir[3]);
      hit_rec_type r;
      cls_type     cls[3];
      q_type       t[3];
      q_type       crd[3];
      logic        in_box;
      int          w;
      logic signed [127:0] num, den, quo, prod, mag, s;
      r = '0;
      in_box = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (org[i] < bmin[i]) begin
            cls[i] = CLS_BELOW; in_box = 1'b0;
         end else if (bmax[i] < org[i]) begin
            cls[i] = CLS_ABOVE; in_box = 1'b0;
         end else begin
            cls[i] = CLS_WITHIN;
         end
      end
      if (in_box) begin
         r.hit = 1'b1; r.x = org[0]; r.y = org[1]; r.z = org[2];
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         if (cls[i] == CLS_WITHIN || dir[i] == 0) begin
            t[i] = -(32'sd1 <<< FB);
         end else begin
            num = (cls[i] == CLS_BELOW) ? 128'(bmin[i]) - 128'(org[i])
                                        : 128'(bmax[i]) - 128'(org[i]);
            den = 128'(dir[i]);
            quo = (num <<< FB) / den;   // truncates toward zero
            t[i] = sat_q(quo);
         end
      end
      w = 0;
      for (int i = 1; i < 3; i++) if (t[w] < t[i]) w = i;
      if (t[w] < 0) return r;
      for (int i = 0; i < 3; i++) begin
         if (i == w) begin
            crd[i] = (cls[i] == CLS_BELOW) ? bmin[i] : bmax[i];
         end else begin
            prod = 128'(t[w]) * 128'(dir[i]);
            mag = (prod < 0) ? -prod : prod;
            mag = mag >>> FB;
            s = 128'(org[i]) + 128'(sat_q((prod < 0) ? -mag : mag));
            // leaving the word is a miss
            if (s > 128'sd2147483647 || s < -128'sd2147483648) return r;
            if (s < 128'(bmin[i]) || s > 128'(bmax[i])) return r;
            crd[i] = s[31:0];
         end
      end
      r.hit = 1'b1; r.x = crd[0]; r.y = crd[1]; r.z = crd[2];
      return r;
   endfunction

   // Drive one item, wait for its acceptance; predict on acceptance.
   // req_tvalid stays high afterwards; callers drop it before pausing.
   task automatic send_ray(input q_type bmin[3], input q_type bmax[3],
                           input q_type org[3], input q_type dir[3]);
      logic [383:0] d;
      for (int i = 0; i < 3; i++) begin
         d[32*i +: 32]       = bmin[i];
         d[32*(3+i) +: 32]   = bmax[i];
         d[32*(6+i) +: 32]   = org[i];
         d[32*(9+i) +: 32]   = dir[i];
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_hits.push_back(trace_ray(bmin, bmax, org, dir));
   endtask

   // Receiver: random backpressure, compare each item with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result hit=%0d data=%h", $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            hit_rec_type e;
            e = expected_hits.pop_front();
            if (e.hit !== rsp_tuser[0] || e.x !== rsp_tdata[31:0] ||
                e.y !== rsp_tdata[63:32] || e.z !== rsp_tdata[95:64]) begin
               $display("%0t: mismatch expected hit=%0d x=%h y=%h z=%h actual hit=%0d x=%h y=%h z=%h",
                        $time, e.hit, e.x, e.y, e.z, rsp_tuser,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64]);
               fail_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ray_box_intersection_top test failed");
         $finish;
      end
   end

   function automatic q_type rand_q();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'sh80000000 + $urandom_range(3);
         2: return 32'sh7fffffff - $urandom_range(3);
         default: return $signed($urandom_range(20 << FB)) - (10 << FB);
      endcase
   endfunction

   // Box edges, inside origins, zero directions, inverted box, ties, extremes.
   task automatic test_directed();
      q_type mn[3], mx[3], o[3], d[3];
      mn = '{-(1 << FB), -(1 << FB), -(1 << FB)};
      mx = '{ (1 << FB),  (1 << FB),  (1 << FB)};
      o = '{0, 0, 0};              d = '{0, 0, 0};            send_ray(mn, mx, o, d);
      o = '{-(4 << FB), 0, 0};     d = '{1 << FB, 0, 0};      send_ray(mn, mx, o, d);
      o = '{-(4 << FB), 0, 0};     d = '{-(1 << FB), 0, 0};   send_ray(mn, mx, o, d);
      o = '{(4 << FB), 0, 0};      d = '{-(1 << FB), 0, 0};   send_ray(mn, mx, o, d);
      o = '{0, -(4 << FB), 0};     d = '{0, 0, 0};            send_ray(mn, mx, o, d);
      o = '{-(3 << FB), -(3 << FB), -(3 << FB)};
      d = '{1 << FB, 1 << FB, 1 << FB};                       send_ray(mn, mx, o, d);
      o = '{-(1 << FB), 0, (2 << FB)}; d = '{0, 0, -(1 << FB)}; send_ray(mn, mx, o, d);
      o = '{mn[0], mx[1], 0};                                 send_ray(mn, mx, o, d);
      o = '{-(2 << FB), 0, 0};     d = '{1, 32'sh7fffffff, 0}; send_ray(mn, mx, o, d);
      o = '{-(2 << FB), 0, 0};     d = '{1 << FB, 32'sh80000000, 1}; send_ray(mn, mx, o, d);
      o = '{32'sh80000000, 32'sh7fffffff, 0};
      d = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000};    send_ray(mn, mx, o, d);
      mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
      mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      o = '{32'sh80000000, 32'sh7fffffff, 0};                 send_ray(mn, mx, o, d);
      // inverted box: min above max
      mn = '{1 << FB, 0, 0}; mx = '{-(1 << FB), 0, 0};
      o = '{0, 0, 0}; d = '{1 << FB, 0, 0};                   send_ray(mn, mx, o, d);
      o = '{(5 << FB), 0, 0}; d = '{-(1 << FB), 0, 0};        send_ray(mn, mx, o, d);
      mn = '{0, 0, 0}; mx = '{2, 32'sh7fffffff, 0};
      o = '{-1, 32'sh80000000, 0}; d = '{32'sh7fffffff, 32'sh7fffffff, 0}; send_ray(mn, mx, o, d);
   endtask

   // Random rays, about half of the direction components aimed at the box so hits and plane picks are exercised.
   task automatic test_random(input int count);
      q_type mn[3], mx[3], o[3], d[3], a, b;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 3; i++) begin
            a = rand_q(); b = rand_q();
            if ($urandom_range(9) != 0 && a > b) begin mn[i] = b; mx[i] = a; end
            else begin mn[i] = a; mx[i] = b; end
            o[i] = rand_q();
            if ($urandom_range(3) == 0) d[i] = 0;
            else if ($urandom_range(2) == 0) d[i] = rand_q();
            else d[i] = $signed(mn[i] / 2 + mx[i] / 2) / 4 - o[i] / 4;
         end
         send_ray(mn, mx, o, d);
      end
   endtask

   // Sender holds off until the pipe is empty, then resumes.
   task automatic test_drain_pause();
      test_random(20);
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      test_random(20);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 21; recv_idle_pct = 67;
      test_directed();
      test_random(160);
      send_idle_pct = 67; recv_idle_pct = 21;
      test_drain_pause();
      test_random(120);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(160);
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("ray_box_intersection_top test passed");
      end else begin
         $display("ray_box_intersection_top test failed");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+design
design/rbi_pkg.sv
design/rbi_classify.sv
design/rbi_div.sv
design/rbi_scale.sv
design/ray_box_intersection_top.sv
design/rbi_checker.sv
tb/sv/ray_box_intersection_top_tb.sv
